// File: rtl/sharpen_3x3_stencil_defines.svh
// Assertion macros shared by the sharpen stencil RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SHARPEN_3X3_STENCIL_DEFINES_SVH
`define SHARPEN_3X3_STENCIL_DEFINES_SVH

// Checked on every rising clk_i edge, ignored while rst_ni is low.
`define SHP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Checked on every rising clk_i edge, reset included.
`define SHP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`endif

// File: rtl/shp_pkg.sv
// Constants, types and register codes for the 3x3 sharpen stencil.
// No dependencies; used by the stencil top, the kernel lane and the testbench.
package shp_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int CoordW    = 11;
  localparam int ChanW     = 8;
  localparam int NumChan   = 3;
  localparam int PixW      = NumChan * ChanW;
  localparam int LineW     = 2 * PixW;
  localparam int CfgDataW  = 12;
  localparam int CfgIdxW   = 2;
  // compare width for column against the effective frame width
  localparam int WCmpW     = (ColW + 1 > CfgDataW) ? ColW + 1 : CfgDataW;
  localparam int HCmpW     = (RowW + 1 > CfgDataW) ? RowW + 1 : CfgDataW;

  localparam logic [CfgDataW-1:0] FrameWidthRst  = CfgDataW'(640);
  localparam logic [CfgDataW-1:0] FrameHeightRst = CfgDataW'(480);
  localparam logic                ColorModeRst   = 1'b0;
  localparam int                  MinDim         = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1,
    RegColorMode   = 2'd2
  } cfg_reg_e;

  typedef logic [PixW-1:0] pix_t;

  // one channel's 5-point neighborhood
  typedef struct packed {
    logic [ChanW-1:0] center;
    logic [ChanW-1:0] up;
    logic [ChanW-1:0] down;
    logic [ChanW-1:0] left;
    logic [ChanW-1:0] right;
  } nbr_t;

endpackage

// File: rtl/shp_if.sv
// Valid/ready channel interfaces for sharpen stencil pixels in and out.
// No dependencies.
interface shp_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_frame;
  logic [7:0] chan_zero;
  logic [7:0] chan_one;
  logic [7:0] chan_two;

  modport source (output valid, start_of_frame, chan_zero, chan_one, chan_two,
                  input ready);
  modport sink (input valid, start_of_frame, chan_zero, chan_one, chan_two,
                output ready);
endinterface

interface shp_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] out_row;
  logic [10:0] out_col;
  logic [7:0]  sharp_zero;
  logic [7:0]  sharp_one;
  logic [7:0]  sharp_two;

  modport source (output valid, out_row, out_col, sharp_zero, sharp_one, sharp_two,
                  input ready);
  modport sink (input valid, out_row, out_col, sharp_zero, sharp_one, sharp_two,
                output ready);
endinterface

// File: rtl/sharpen_3x3_stencil.sv
// 3x3 Laplacian sharpen over a raster pixel stream, one or three 8-bit channels.
// Depends on shp_pkg, shp_if, shp_ram, shp_lane and the assertion macro header.
//
// Sustained rate is one pixel item per clock: a pixel is accepted every cycle
// stage one is empty or moving on, and it moves on whenever the output register
// is free or being drained. There are two register stages (line buffer read,
// then kernel lanes into the output register): an accepted pixel is held in
// stage one, then its result moves into the output register and waits there
// while the sink stalls. Both line buffers share one 48-bit RAM word per column,
// read at accept and written back as the item leaves stage one; a same-column
// read in the cycle of that write is forwarded. The result for center (r-1, c-1)
// leaves when pixel (r, c) has gone in; nothing is emitted for row 0 or column 0
// inputs, and the first output row and column carry zero data. Three kernel
// lanes run in parallel, one per channel; in grayscale the second and third
// lanes are held at zero. The user must write frame_width, frame_height and
// color_mode through the cfg port only while no item is in flight; the block
// itself does not enforce this. There is no clearing pass after reset.
`include "sharpen_3x3_stencil_defines.svh"

module sharpen_3x3_stencil (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  shp_in_if.sink                        pix_i,
  shp_out_if.source                     sharp_o,
  input  logic                          cfg_we_i,
  input  logic [shp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [shp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import shp_pkg::*;

  // configuration
  logic [CfgDataW-1:0] frame_width_q, frame_height_q;
  logic                color_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
      color_mode_q   <= ColorModeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegFrameWidth:  frame_width_q  <= cfg_data_i;
        RegFrameHeight: frame_height_q <= cfg_data_i;
        RegColorMode:   color_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp registers to the supported range
  logic [WCmpW-1:0] width_eff;
  logic [HCmpW-1:0] height_eff;

  always_comb begin
    width_eff = WCmpW'(frame_width_q);
    if (width_eff < WCmpW'(MinDim)) begin
      width_eff = WCmpW'(MinDim);
    end else if (width_eff > WCmpW'(MaxWidth)) begin
      width_eff = WCmpW'(MaxWidth);
    end
    height_eff = HCmpW'(frame_height_q);
    if (height_eff < HCmpW'(MinDim)) begin
      height_eff = HCmpW'(MinDim);
    end else if (height_eff > HCmpW'(MaxHeight)) begin
      height_eff = HCmpW'(MaxHeight);
    end
  end

  // handshake
  logic in_acc, s1_adv;
  logic s1_valid_q, out_valid_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || sharp_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_acc      = pix_i.valid && pix_i.ready;

  // position counters: place of the arriving pixel and the one after it
  logic [ColW-1:0]  col_q, col_d, col_base, col_cur;
  logic [RowW-1:0]  row_q, row_d, row_base;
  logic [HCmpW-1:0] row_tmp, row_cur, row_inc;
  logic [WCmpW-1:0] col_inc;

  always_comb begin
    col_base = pix_i.start_of_frame ? '0 : col_q;
    row_base = pix_i.start_of_frame ? '0 : row_q;
    col_cur  = col_base;
    row_tmp  = HCmpW'(row_base);
    if (WCmpW'(col_base) >= width_eff) begin
      col_cur = '0;
      row_tmp = HCmpW'(row_base) + HCmpW'(1);
    end
    row_cur = (row_tmp >= height_eff) ? '0 : row_tmp;

    col_inc = WCmpW'(col_cur) + WCmpW'(1);
    row_inc = row_cur + HCmpW'(1);
    if (col_inc >= width_eff) begin
      col_d = '0;
      row_d = (row_inc >= height_eff) ? '0 : row_inc[RowW-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = row_cur[RowW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line buffer word is in the RAM output register
  logic [RowW-1:0]  s1_row_q;
  logic [ColW-1:0]  s1_col_q;
  pix_t             s1_px_q;
  logic             fwd_q;
  logic [LineW-1:0] fwd_word_q;
  logic [LineW-1:0] ram_rdata, line_word, ram_wdata;
  pix_t             one_up, two_up;

  assign line_word = fwd_q ? fwd_word_q : ram_rdata;
  assign one_up    = line_word[LineW-1:PixW];
  assign two_up    = line_word[PixW-1:0];
  // new pixel becomes one row up, old one-up becomes two rows up
  assign ram_wdata = {s1_px_q, one_up};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      fwd_q      <= s1_adv && (s1_col_q == col_cur);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_row_q   <= row_cur[RowW-1:0];
      s1_col_q   <= col_cur;
      s1_px_q    <= {pix_i.chan_two, pix_i.chan_one, pix_i.chan_zero};
      fwd_word_q <= ram_wdata;
    end
  end

  shp_ram #(
    .Width (LineW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  // window: left column only needs its center; middle column is full
  pix_t win_mid_q, win_up_q, win_ctr_q, win_dn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_mid_q <= '0;
      win_up_q  <= '0;
      win_ctr_q <= '0;
      win_dn_q  <= '0;
    end else if (s1_adv) begin
      win_mid_q <= win_ctr_q;
      win_up_q  <= two_up;
      win_ctr_q <= one_up;
      win_dn_q  <= s1_px_q;
    end
  end

  // kernel lanes, one per channel, on the registered window plus the right neighbor from stage one
  logic             emit, interior;
  logic [ChanW-1:0] lane_sharp [NumChan];

  assign emit     = (s1_row_q != '0) && (s1_col_q != '0);
  assign interior = (s1_row_q > RowW'(1)) && (s1_col_q > ColW'(1));

  for (genvar k = 0; k < NumChan; k++) begin : g_lane
    nbr_t nbr;
    assign nbr.center = win_ctr_q[k*ChanW +: ChanW];
    assign nbr.up     = win_up_q[k*ChanW +: ChanW];
    assign nbr.down   = win_dn_q[k*ChanW +: ChanW];
    assign nbr.left   = win_mid_q[k*ChanW +: ChanW];
    assign nbr.right  = one_up[k*ChanW +: ChanW];

    shp_lane u_lane (
      .nbr_i   (nbr),
      .en_i    (interior && ((k == 0) || color_mode_q)),
      .sharp_o (lane_sharp[k])
    );
  end

  // merge lanes into the output register
  logic [CoordW-1:0] out_row_q, out_col_q;
  logic [ChanW-1:0]  sharp_q [NumChan];
  logic              out_nonzero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= emit;
    end else if (sharp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_row_q <= CoordW'(s1_row_q - RowW'(1));
      out_col_q <= CoordW'(s1_col_q - ColW'(1));
      for (int k = 0; k < NumChan; k++) begin
        sharp_q[k] <= lane_sharp[k];
      end
    end
  end

  assign sharp_o.valid      = out_valid_q;
  assign sharp_o.out_row    = out_row_q;
  assign sharp_o.out_col    = out_col_q;
  assign sharp_o.sharp_zero = sharp_q[0];
  assign sharp_o.sharp_one  = sharp_q[1];
  assign sharp_o.sharp_two  = sharp_q[2];

  assign out_nonzero = (sharp_q[0] != '0) || (sharp_q[1] != '0) || (sharp_q[2] != '0);

  // checks
  `SHP_ASSERT(a_fwd_only_with_item, fwd_q |-> s1_valid_q)
  `SHP_ASSERT(a_accept_fills_s1, in_acc |=> s1_valid_q)
  `SHP_ASSERT(a_s1_holds, (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_col_q)))
  `SHP_ASSERT(a_edge_zero, (out_valid_q && out_nonzero) |-> (out_row_q != '0 && out_col_q != '0))

endmodule

// File: rtl/shp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies. Read returns the old word on a same-address write.
module shp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/shp_lane.sv
// One channel of the 5-point sharpen kernel with saturation to 0..255.
// Depends on shp_pkg.
module shp_lane (
  input  shp_pkg::nbr_t                  nbr_i,
  input  logic                           en_i,
  output logic [shp_pkg::ChanW-1:0]      sharp_o
);
  import shp_pkg::*;

  logic [ChanW+2:0]        center_x5;
  logic [ChanW+1:0]        nbr_sum;
  logic signed [ChanW+3:0] acc;

  always_comb begin
    center_x5 = {1'b0, nbr_i.center, 2'b00} + (ChanW+3)'(nbr_i.center);
    nbr_sum   = (ChanW+2)'(nbr_i.up) + (ChanW+2)'(nbr_i.down)
              + (ChanW+2)'(nbr_i.left) + (ChanW+2)'(nbr_i.right);
    acc       = $signed({1'b0, center_x5}) - $signed({2'b00, nbr_sum});
    if (!en_i || acc[ChanW+3]) begin
      sharp_o = '0;
    end else if (acc[ChanW+2:ChanW] != '0) begin
      sharp_o = '1;
    end else begin
      sharp_o = acc[ChanW-1:0];
    end
  end

endmodule

// File: dv/testbench.sv
// Testbench for sharpen_3x3_stencil: a directed stencil table with hand-typed results, then
// random frames over several frame geometries, checked against a built-in sharpen predictor.
// Depends on shp_pkg, shp_in_if and shp_out_if from the RTL.
module testbench;
  import shp_pkg::*;

  // Drain time for the pipeline, with margin for items that leave no result.
  localparam int DrainCycles = 4;
  // Time limit for the whole run, with a wide margin.
  localparam int LimitTime   = 2_000_000;

  typedef struct packed {
    logic [10:0]      row;
    logic [10:0]      col;
    logic [ChanW-1:0] s0;
    logic [ChanW-1:0] s1;
    logic [ChanW-1:0] s2;
  } sharp_res_t;

  // One directed item: input fields, then the typed result where one is checked by hand.
  typedef struct packed {
    logic             sof;
    logic [ChanW-1:0] c0;
    logic [ChanW-1:0] c1;
    logic [ChanW-1:0] c2;
    logic             typed;
    sharp_res_t       res;
  } dir_row_t;

  localparam sharp_res_t NoRes = '0;

  // Two 3x3 color frames and a short broken one, width and height both 3.
  // Frame one: lone bright center, neighbors black; the kernel saturates high
  // on channel zero and two, lands just under the top on channel one.
  // Frame two follows with no start marker (row wrap): dark center on white,
  // giving a low clip, an exact zero and a small positive value.
  // The last four items emit nothing: a third frame starts, and a start marker restarts it mid-row.
  localparam dir_row_t DirTbl [22] = '{
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{1'b0, 8'hFF, 8'h32, 8'h34, 1'b1, '{11'd0, 11'd0, 8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, '{11'd0, 11'd1, 8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, '{11'd1, 11'd0, 8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, '{11'd1, 11'd1, 8'hFF, 8'hFA, 8'hFF}},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, NoRes},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, NoRes},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, NoRes},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, NoRes},
    '{1'b0, 8'h00, 8'hCC, 8'hCD, 1'b1, '{11'd0, 11'd0, 8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{11'd0, 11'd1, 8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, NoRes},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{11'd1, 11'd0, 8'h00, 8'h00, 8'h00}},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{11'd1, 11'd1, 8'h00, 8'h00, 8'h05}},
    '{1'b0, 8'h5A, 8'hA5, 8'h3C, 1'b0, NoRes},
    '{1'b0, 8'h11, 8'h22, 8'h33, 1'b0, NoRes},
    '{1'b1, 8'hC3, 8'h3C, 8'h81, 1'b0, NoRes},
    '{1'b0, 8'h7E, 8'hE7, 8'h18, 1'b0, NoRes}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  shp_in_if  pix_if ();
  shp_out_if sharp_if ();

  sharpen_3x3_stencil dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .sharp_o    (sharp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Sharpen predictor: its own line buffers, window, position and registers.
  // ---------------------------------------------------------------------------
  pix_t                line_above [MaxWidth];
  pix_t                line_two_above [MaxWidth];
  pix_t                win [9];          // row-major, top row first, newest column right
  int                  cur_row;
  int                  cur_col;
  logic [CfgDataW-1:0] cfg_width;
  logic [CfgDataW-1:0] cfg_height;
  logic                cfg_color;

  sharp_res_t          pending_sharp_q [$];   // sharpened pixels still owed by the block

  int send_gap_pct;
  int recv_stall_pct;
  int pixels_sent;
  int sharp_checked;
  int mismatches;
  int settings_run;
  int smooth_level;

  // 5*center minus the four side neighbors of channel k, clipped to a byte.
  function automatic logic [ChanW-1:0] sharpen_lane(input int k);
    nbr_t n;
    int   v;
    n.center = win[4][8*k +: 8];
    n.up     = win[1][8*k +: 8];
    n.down   = win[7][8*k +: 8];
    n.left   = win[3][8*k +: 8];
    n.right  = win[5][8*k +: 8];
    v = 5 * int'(n.center) - int'(n.up) - int'(n.down) - int'(n.left) - int'(n.right);
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  // Advances the predictor by one pixel; returns 1 when the pixel yields a result.
  function automatic bit sharpen_step(input logic sof, input pix_t px,
                                      output sharp_res_t res);
    int w;
    int h;
    int r;
    int c;
    int i;
    bit has;
    // out-of-range geometry is clamped, not rejected
    w = (cfg_width < MinDim) ? MinDim : (cfg_width > MaxWidth) ? MaxWidth : cfg_width;
    h = (cfg_height < MinDim) ? MinDim : (cfg_height > MaxHeight) ? MaxHeight : cfg_height;
    if (sof) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    r = cur_row;
    c = cur_col;
    for (i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2] = line_two_above[c];
    win[5] = line_above[c];
    win[8] = px;
    line_two_above[c] = line_above[c];
    line_above[c]     = px;
    res = '0;
    has = (r >= 1 && c >= 1);
    if (has) begin
      res.row = 11'(r - 1);
      res.col = 11'(c - 1);
      // first output row and column stay zero
      if (r >= 2 && c >= 2) begin
        res.s0 = sharpen_lane(0);
        if (cfg_color) begin
          res.s1 = sharpen_lane(1);
          res.s2 = sharpen_lane(2);
        end
      end
    end
    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= h) cur_row = 0;
    end
    return has;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and time limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(LimitTime);
    $display("Timeout at %0t with %0d sharpened pixels outstanding",
             $time, pending_sharp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pixel sender. Drives at the rising edge, samples ready as it stood before
  // the edge, and predicts the moment an item goes in. valid is left high so
  // the next item can follow back to back; callers lower it when done.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic sof, input pix_t px, input logic typed,
                            input sharp_res_t typed_res);
    sharp_res_t res;
    bit         has;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid          <= 1'b1;
    pix_if.start_of_frame <= sof;
    pix_if.chan_zero      <= px[7:0];
    pix_if.chan_one       <= px[15:8];
    pix_if.chan_two       <= px[23:16];
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    has = sharpen_step(sof, px, res);
    // hand-typed rows override the predictor; the predictor still tracks state
    if (typed) pending_sharp_q.push_back(typed_res);
    else if (has) pending_sharp_q.push_back(res);
    pixels_sent++;
  endtask

  // Registers change only with the block empty: all results back, then the
  // pipeline given time to retire pixels that leave no result behind.
  task automatic configure(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                           input logic color);
    pix_if.valid <= 1'b0;
    while (pending_sharp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegFrameWidth;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_width = w;
    cfg_idx  <= RegFrameHeight;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_height = h;
    cfg_idx  <= RegColorMode;
    cfg_data <= CfgDataW'(color);
    @(posedge clk_i);
    cfg_color = color;
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Mix of hard black/white, smooth texture around a per-frame level, and noise,
  // so the kernel lands in range as often as it clips.
  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1, 2:    return ChanW'(smooth_level + $urandom_range(0, 16) - 8);
      default: return ChanW'($urandom);
    endcase
  endfunction

  // Random frames under one geometry. The first item always carries the start
  // marker so a width change never lands mid-frame; later frames start with or
  // without it (row wrap). With noise set, a stray marker now and then cuts a
  // frame short.
  task automatic run_frames(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                            input logic color, input int count, input bit noise);
    logic sof;
    pix_t px;
    bit   at_start;
    configure(w, h, color);
    for (int n = 0; n < count; n++) begin
      at_start = (cur_row == 0 && cur_col == 0);
      if (n == 0 || at_start) smooth_level = $urandom_range(8, 247);
      if (n == 0) sof = 1'b1;
      else if (at_start) sof = $urandom_range(0, 1);
      else sof = noise && ($urandom_range(0, 99) == 0);
      px = {rand_chan(), rand_chan(), rand_chan()};
      send_pixel(sof, px, 1'b0, NoRes);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker. ready is redrawn every cycle; results are
  // compared in order against the oldest owed sharpened pixel.
  // ---------------------------------------------------------------------------
  initial begin
    sharp_res_t got;
    sharp_res_t want;
    sharp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && sharp_if.valid === 1'b1 && sharp_if.ready === 1'b1) begin
        got = '{sharp_if.out_row, sharp_if.out_col, sharp_if.sharp_zero,
                sharp_if.sharp_one, sharp_if.sharp_two};
        if (pending_sharp_q.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got row %0d col %0d %02h %02h %02h", $time,
                   got.row, got.col, got.s0, got.s1, got.s2);
        end else begin
          want = pending_sharp_q.pop_front();
          sharp_checked++;
          if (got.row !== want.row || got.col !== want.col || got.s0 !== want.s0 ||
              got.s1 !== want.s1 || got.s2 !== want.s2) begin
            mismatches++;
            $display("%0t: expected row %0d col %0d %02h %02h %02h,", $time,
                     want.row, want.col, want.s0, want.s1, want.s2);
            $display("%0t:      got row %0d col %0d %02h %02h %02h", $time,
                     got.row, got.col, got.s0, got.s1, got.s2);
          end
        end
      end
      sharp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    pix_if.valid          <= 1'b0;
    pix_if.start_of_frame <= 1'b0;
    pix_if.chan_zero      <= '0;
    pix_if.chan_one       <= '0;
    pix_if.chan_two       <= '0;
    cfg_we                <= 1'b0;
    cfg_idx               <= RegFrameWidth;
    cfg_data              <= '0;
    rst_ni                <= 1'b0;

    // predictor starts from the block's reset state
    for (int i = 0; i < MaxWidth; i++) begin
      line_above[i]     = '0;
      line_two_above[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    cur_row        = 0;
    cur_col        = 0;
    cfg_width      = FrameWidthRst;
    cfg_height     = FrameHeightRst;
    cfg_color      = ColorModeRst;
    pixels_sent    = 0;
    sharp_checked  = 0;
    mismatches     = 0;
    settings_run   = 0;
    smooth_level   = 128;
    send_gap_pct   = 10;
    recv_stall_pct = 49;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame, color: hand-checked table
    configure(12'd3, 12'd3, 1'b1);
    foreach (DirTbl[k])
      send_pixel(DirTbl[k].sof, {DirTbl[k].c2, DirTbl[k].c1, DirTbl[k].c0},
                 DirTbl[k].typed, DirTbl[k].res);

    // sender idles a little, receiver stalls about half the time
    run_frames(12'd7, 12'd5, 1'b0, 90, 1'b1);

    // the other way round; width and height written below range clamp to 3
    send_gap_pct   = 49;
    recv_stall_pct = 10;
    run_frames(12'd0, 12'd2, 1'b1, 70, 1'b1);
    run_frames(12'd12, 12'd4, 1'b1, 100, 1'b1);

    // full rate; narrowest width with the height written above range
    // (clamps to 2048), then a small gray frame
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_frames(12'd1, 12'hFFF, 1'b1, 80, 1'b0);
    run_frames(12'd5, 12'd9, 1'b0, 90, 1'b1);

    pix_if.valid <= 1'b0;
    while (pending_sharp_q.size() != 0) @(posedge clk_i);
    repeat (2 * DrainCycles) @(posedge clk_i);

    $display("Sent %0d pixels over %0d frame geometries (3 to 12 wide, gray and color).",
             pixels_sent, settings_run);
    $display("Compared %0d sharpened pixels; %0d mismatches.", sharp_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
